>>> rtl/sal_pkg.sv
`default_nettype none

package sal_pkg;

    localparam int unsigned TYPE_W   = 8;
    localparam int unsigned CODE_W   = 16;
    localparam int unsigned VALUE_W  = 16;
    localparam int unsigned TIME_W   = 32;
    localparam int unsigned CFG_W    = 16;
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned MAG_W    = 14;

    localparam logic [MAG_W-1:0] MAG_LIMIT = 14'd10000;

    // Register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_MATCH_TYPE  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_VERT_CODE   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HORIZ_CODE  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_RELEASE     = 3'd4;

    // Reset values of the registers
    localparam logic [TYPE_W-1:0] RST_MATCH_TYPE = 8'd2;
    localparam logic [CODE_W-1:0] RST_VERT_CODE  = 16'd8;
    localparam logic [CODE_W-1:0] RST_HORIZ_CODE = 16'd6;
    localparam logic [CFG_W-1:0]  RST_THRESHOLD  = 16'd6;
    localparam logic [CFG_W-1:0]  RST_RELEASE    = 16'd200;

    typedef enum logic [1:0] {
        LOCK_FREE  = 2'd0,
        LOCK_VERT  = 2'd1,
        LOCK_HORIZ = 2'd2
    } lock_t;

    typedef struct packed {
        logic [TYPE_W-1:0] match_type;
        logic [CODE_W-1:0] vertical_code;
        logic [CODE_W-1:0] horizontal_code;
        logic [CFG_W-1:0]  engage_threshold;
        logic [CFG_W-1:0]  release_time_ms;
    } sal_cfg_t;

    typedef struct packed {
        logic [TYPE_W-1:0]         ev_type;
        logic [CODE_W-1:0]         ev_code;
        logic signed [VALUE_W-1:0] value_in;
        logic                      report_end;
        logic [TIME_W-1:0]         time_ms;
    } sal_item_t;

    typedef struct packed {
        logic [MAG_W-1:0]  vert_mag;
        logic [MAG_W-1:0]  horiz_mag;
        logic [TIME_W-1:0] last_time;
        lock_t             lock_axis;
    } sal_state_t;

    typedef struct packed {
        logic signed [VALUE_W-1:0] value_out;
        lock_t                     lock_now;
    } sal_result_t;

endpackage

`default_nettype wire

>>> rtl/sal_cfg_regs.sv
`default_nettype none

module sal_cfg_regs
    import sal_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_data,
    output sal_cfg_t                  cfg
);

    sal_cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.match_type       <= RST_MATCH_TYPE;
            cfg_reg.vertical_code    <= RST_VERT_CODE;
            cfg_reg.horizontal_code  <= RST_HORIZ_CODE;
            cfg_reg.engage_threshold <= RST_THRESHOLD;
            cfg_reg.release_time_ms  <= RST_RELEASE;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_MATCH_TYPE: cfg_reg.match_type       <= cfg_data[TYPE_W-1:0];
                CFG_VERT_CODE:  cfg_reg.vertical_code    <= cfg_data[CODE_W-1:0];
                CFG_HORIZ_CODE: cfg_reg.horizontal_code  <= cfg_data[CODE_W-1:0];
                CFG_THRESHOLD:  cfg_reg.engage_threshold <= cfg_data;
                CFG_RELEASE:    cfg_reg.release_time_ms  <= cfg_data;
                default:        ; // drop writes to unused indexes
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

>>> rtl/sal_update.sv
`default_nettype none

module sal_update
    import sal_pkg::*;
(
    input  wire sal_cfg_t   cfg,
    input  wire sal_item_t  item,
    input  wire sal_state_t state,
    output sal_state_t      state_next,
    output sal_result_t     result
);

    function automatic logic [MAG_W-1:0] add_sat(input logic [MAG_W-1:0] mag,
                                                 input logic [VALUE_W:0]  inc);
        logic [MAG_W+3:0] sum;
        sum = {4'b0, mag} + {{(MAG_W+3-VALUE_W){1'b0}}, inc};
        return (sum > {4'b0, MAG_LIMIT}) ? MAG_LIMIT : sum[MAG_W-1:0];
    endfunction

    function automatic logic [MAG_W-1:0] decay(input logic [MAG_W-1:0] mag);
        return mag - (mag >> 2);
    endfunction

    logic               type_hit;
    logic               hit_v;
    logic               hit_h;
    logic [TIME_W-1:0]  gap;
    logic               expired;
    logic [MAG_W-1:0]   base_v;
    logic [MAG_W-1:0]   base_h;
    lock_t              base_lock;
    logic [VALUE_W:0]   mag_in;
    logic [MAG_W-1:0]   add_v;
    logic [MAG_W-1:0]   add_h;
    logic [MAG_W-1:0]   dec_v;
    logic [MAG_W-1:0]   dec_h;
    logic               vert_wins;
    lock_t              winner;
    logic [MAG_W-1:0]   win;
    logic [MAG_W-1:0]   lose;
    logic               engage;
    lock_t              lock_new;
    logic               suppress;

    always_comb
    begin
        type_hit = (item.ev_type == cfg.match_type);
        // The vertical code takes precedence when both codes are equal
        hit_v    = type_hit && (item.ev_code == cfg.vertical_code);
        hit_h    = type_hit && !hit_v && (item.ev_code == cfg.horizontal_code);

        gap      = item.time_ms - state.last_time;
        expired  = (gap >= {{(TIME_W-CFG_W){1'b0}}, cfg.release_time_ms});

        base_v    = expired ? '0 : state.vert_mag;
        base_h    = expired ? '0 : state.horiz_mag;
        base_lock = expired ? LOCK_FREE : state.lock_axis;

        // Absolute value; the most negative input yields 32768
        mag_in = item.value_in[VALUE_W-1]
               ? ((VALUE_W+1)'(1) << VALUE_W) - {1'b0, item.value_in}
               : {1'b0, item.value_in};

        add_v = hit_v ? add_sat(base_v, mag_in) : base_v;
        add_h = hit_h ? add_sat(base_h, mag_in) : base_h;

        dec_v = decay(add_v);
        dec_h = decay(add_h);

        vert_wins = (dec_v >= dec_h);
        winner    = vert_wins ? LOCK_VERT : LOCK_HORIZ;
        win       = vert_wins ? dec_v : dec_h;
        lose      = vert_wins ? dec_h : dec_v;

        engage = ({{(CFG_W-MAG_W){1'b0}}, win} >= cfg.engage_threshold)
              && ((base_lock == LOCK_FREE)
                  || ((winner != base_lock) && ({1'b0, win} >= {lose, 1'b0})));

        lock_new = base_lock;
        if (item.report_end && engage)
        begin
            lock_new = winner;
        end

        suppress = (lock_new == LOCK_FREE)
                || ((lock_new == LOCK_VERT) && !hit_v)
                || ((lock_new == LOCK_HORIZ) && hit_v);

        if (hit_v || hit_h)
        begin
            state_next.vert_mag  = item.report_end ? dec_v : add_v;
            state_next.horiz_mag = item.report_end ? dec_h : add_h;
            state_next.last_time = item.time_ms;
            state_next.lock_axis = lock_new;
            result.value_out     = suppress ? '0 : item.value_in;
            result.lock_now      = lock_new;
        end
        else
        begin
            state_next       = state;
            result.value_out = item.value_in;
            result.lock_now  = state.lock_axis;
        end
    end

endmodule

`default_nettype wire

>>> rtl/scroll_axis_lock_filter.sv
// An accepted word waits in the input register; its result is loaded into the
// result register as it advances. Throughput: one word per cycle while
// out_ready is high; one new word is taken while a result waits.
// The filter update is one short combinational pass between the input
// register and the result register; the state register closes that loop.
// Reset (rst_n low, asynchronous): magnitudes, timestamp and lock cleared,
// registers back to their defaults, both pipeline stages empty.
`default_nettype none

module scroll_axis_lock_filter
    import sal_pkg::*;
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,

    // Configuration write port
    input  wire logic                       cfg_we,
    input  wire logic [CFG_IDX_W-1:0]       cfg_index,
    input  wire logic [CFG_W-1:0]           cfg_data,

    // Input event channel
    input  wire logic                       in_valid,
    output logic                            in_ready,
    input  wire logic [TYPE_W-1:0]          ev_type,
    input  wire logic [CODE_W-1:0]          ev_code,
    input  wire logic signed [VALUE_W-1:0]  value_in,
    input  wire logic                       report_end,
    input  wire logic [TIME_W-1:0]          time_ms,

    // Result channel
    output logic                            out_valid,
    input  wire logic                       out_ready,
    output logic signed [VALUE_W-1:0]       value_out,
    output logic [1:0]                      lock_now
);

    sal_cfg_t    cfg;

    logic        in_valid_reg;
    sal_item_t   item_reg;
    sal_state_t  state_reg;
    sal_state_t  state_next;
    logic        out_valid_reg;
    sal_result_t result_reg;
    sal_result_t result_next;

    logic        in_take;
    logic        advance;

    sal_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Advance the held word into the result register whenever that register
    // is empty or its word is being taken this cycle.
    assign advance  = !out_valid_reg || out_ready;
    assign in_ready = !in_valid_reg || advance;
    assign in_take  = in_valid && in_ready;

    // Input register: hold the accepted word until it advances
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            item_reg.ev_type    <= ev_type;
            item_reg.ev_code    <= ev_code;
            item_reg.value_in   <= value_in;
            item_reg.report_end <= report_end;
            item_reg.time_ms    <= time_ms;
        end
    end

    sal_update u_update (
        .cfg        (cfg),
        .item       (item_reg),
        .state      (state_reg),
        .state_next (state_next),
        .result     (result_next)
    );

    // Filter state: update only when a word leaves the input register, so
    // each word sees the state left by the one before it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.vert_mag  <= '0;
            state_reg.horiz_mag <= '0;
            state_reg.last_time <= '0;
            state_reg.lock_axis <= LOCK_FREE;
        end
        else if (in_valid_reg && advance)
        begin
            state_reg <= state_next;
        end
    end

    // Result register: drop the word once taken, load the next one
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid_reg && advance)
        begin
            result_reg <= result_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign value_out = result_reg.value_out;
    assign lock_now  = result_reg.lock_now;

endmodule

`default_nettype wire

>>> rtl/sal_checker.sv
`default_nettype none

module sal_checker
    import sal_pkg::*;
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       in_valid,
    input  wire logic                       in_ready,
    input  wire logic                       out_valid,
    input  wire logic                       out_ready,
    input  wire logic signed [VALUE_W-1:0]  value_out,
    input  wire logic [1:0]                 lock_now
);

    logic in_take;
    assign in_take = in_valid && in_ready;

    // A stalled result word stays valid
    a_out_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result word dropped while stalled");

    // A stalled result word keeps its payload
    a_out_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(value_out) && $stable(lock_now))
        else $error("result payload changed while stalled");

    // With no result waiting, the input side never stalls
    a_in_free: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with result register empty");

    // A new result appears only after an accepted word has passed the input register
    a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_take, 2))
        else $error("result word without a matching input word");

endmodule

bind scroll_axis_lock_filter sal_checker u_sal_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .value_out (value_out),
    .lock_now  (lock_now)
);

`default_nettype wire
